### sv/sha1md_pkg.sv
// shared types and constants for the sha-1 message digest unit
package sha1md_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_CLOAD,
        ST_CROUND,
        ST_CADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } bsel_t;

    typedef struct packed {
        logic       shift_en;
        bsel_t      bsel;
        logic       count_en;
        logic       load_vars;
        logic       round_en;
        logic       chain_add;
        logic       msg_reset;
        logic [2:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at56;
        logic round_last;
    } dp_stat_t;

    localparam logic [1:0] FUNC_DATA = 2'd0;
    localparam logic [1:0] FUNC_LAST = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [6:0] ROUND_LAST    = 7'd79;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] FILL_LEN      = 6'd56;

endpackage

### sv/sha1_message_digest_unit.sv
// top level of the sha-1 message digest unit
//
// input channel: one beat carries func and data_byte. func 0 appends a byte,
// func 1 appends a byte and ends the message, func 2 ends the message with
// no byte (an empty message is allowed), func 3 is dropped with no effect.
// output channel: five beats per message end, digest_word most significant
// first, word_index 0..4, last_word set on the fifth beat.
// a data byte is taken whenever the unit is idle; the 64th byte of a block
// starts the compression (a load of the round variables, the rounds on the
// single round unit, then a chaining add), during which no byte is taken.
// a message end walks the padding one byte a cycle, except while a full block
// is compressed, with an idle turn before the length bytes; it runs one or two
// compressions, then presents the five digest beats.
// in_stall is high whenever the unit is padding, compressing or showing the
// digest; one item is worked on at a time.
// when the receiver stalls, the current digest beat holds unchanged until it
// is taken; the chaining words re-initialize after the fifth beat.
// reset (rst_n low, asynchronous) loads the initial hash values and clears
// the byte count, block fill and round counter; the unit is idle after it.
module sha1_message_digest_unit
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing of intake, padding and rounds
    sha1md_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // block window, round unit and chaining words
    sha1md_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word)
    );

    // digest beat tags follow the controller word counter
    assign word_index = cmd.word_idx;
    assign last_word  = (cmd.word_idx == LAST_WORD_IDX);

endmodule

### sv/sha1md_ctrl.sv
// controller state machine: byte intake, padding, compression sequencing, digest beats
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [2:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.bsel     = BSEL_DATA;
        cmd.word_idx = idx_reg;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (func)
                        FUNC_DATA, FUNC_LAST:
                        begin
                            cmd.shift_en = 1'b1;
                            cmd.bsel     = BSEL_DATA;
                            cmd.count_en = 1'b1;
                            if (stat.fill_last)
                            begin
                                state_next = ST_CLOAD;
                                ret_next   = (func == FUNC_LAST) ? ST_PAD80 : ST_IDLE;
                            end
                            else if (func == FUNC_LAST)
                            begin
                                state_next = ST_PAD80;
                            end
                        end
                        FUNC_END:
                        begin
                            state_next = ST_PAD80;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PAD80:
            begin
                cmd.shift_en = 1'b1;
                cmd.bsel     = BSEL_PAD;
                if (stat.fill_last)
                begin
                    state_next = ST_CLOAD;
                    ret_next   = ST_PADZ;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (stat.fill_at56)
                begin
                    state_next = ST_PADLEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.bsel     = BSEL_ZERO;
                    if (stat.fill_last)
                    begin
                        state_next = ST_CLOAD;
                        ret_next   = ST_PADZ;
                    end
                end
            end
            ST_PADLEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.bsel     = BSEL_LEN;
                if (stat.fill_last)
                begin
                    state_next = ST_CLOAD;
                    ret_next   = ST_OUT;
                end
            end
            ST_CLOAD:
            begin
                cmd.load_vars = 1'b1;
                state_next    = ST_CROUND;
            end
            ST_CROUND:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last)
                begin
                    state_next = ST_CADD;
                end
            end
            ST_CADD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = ret_reg;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (idx_reg == LAST_WORD_IDX)
                    begin
                        cmd.msg_reset = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/sha1md_dp.sv
// datapath: block shift window, round variables, chaining words, byte and length counters
module sha1md_dp
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [31:0] digest_word
);

    logic [511:0] win_reg, win_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  h_reg [5];
    logic [31:0]  h_next [5];
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  len_reg, len_next;
    logic [6:0]   rnd_reg, rnd_next;

    logic [63:0]  bit_len;
    logic [5:0]   len_shift;
    logic [63:0]  len_shifted;
    logic [7:0]   byte_in;
    logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]  f_val, k_val, t_val;

    // byte source for the shift window
    always_comb
    begin
        bit_len     = {len_reg, 3'b000};
        len_shift   = {~fill_reg[2:0], 3'b000};
        len_shifted = bit_len >> len_shift;
        case (cmd.bsel)
            BSEL_DATA: byte_in = data_byte;
            BSEL_PAD:  byte_in = PAD_BYTE;
            BSEL_ZERO: byte_in = 8'h00;
            BSEL_LEN:  byte_in = len_shifted[7:0];
            default:   byte_in = 8'h00;
        endcase
    end

    // message schedule taps, word 0 at the top of the window
    always_comb
    begin
        w0    = win_reg[511:480];
        w2    = win_reg[447:416];
        w8    = win_reg[255:224];
        w13   = win_reg[95:64];
        w_mix = w13 ^ w8 ^ w2 ^ w0;
        w_new = {w_mix[30:0], w_mix[31]};
    end

    always_comb
    begin
        case (rnd_reg) inside
            [7'd0:7'd19]:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K0;
            end
            [7'd20:7'd39]:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K1;
            end
            [7'd40:7'd59]:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K3;
            end
        endcase
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;
    end

    always_comb
    begin
        win_next = win_reg;
        if (cmd.shift_en)
        begin
            win_next = {win_reg[503:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            win_next = {win_reg[479:0], w_new};
        end

        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        rnd_next = rnd_reg;
        if (cmd.load_vars)
        begin
            a_next   = h_reg[0];
            b_next   = h_reg[1];
            c_next   = h_reg[2];
            d_next   = h_reg[3];
            e_next   = h_reg[4];
            rnd_next = '0;
        end
        else if (cmd.round_en)
        begin
            a_next   = t_val;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
            rnd_next = rnd_reg + 7'd1;
        end

        h_next = h_reg;
        if (cmd.msg_reset)
        begin
            h_next[0] = H0;
            h_next[1] = H1;
            h_next[2] = H2;
            h_next[3] = H3;
            h_next[4] = H4;
        end
        else if (cmd.chain_add)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end

        fill_next = fill_reg;
        if (cmd.msg_reset)
        begin
            fill_next = '0;
        end
        else if (cmd.shift_en)
        begin
            fill_next = fill_reg + 6'd1;
        end

        len_next = len_reg;
        if (cmd.msg_reset)
        begin
            len_next = '0;
        end
        else if (cmd.count_en)
        begin
            len_next = len_reg + 61'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= H0;
            h_reg[1] <= H1;
            h_reg[2] <= H2;
            h_reg[3] <= H3;
            h_reg[4] <= H4;
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
        end
        else
        begin
            h_reg    <= h_next;
            fill_reg <= fill_next;
            len_reg  <= len_next;
            rnd_reg  <= rnd_next;
        end
    end

    assign stat.fill_last  = (fill_reg == FILL_LAST);
    assign stat.fill_at56  = (fill_reg == FILL_LEN);
    assign stat.round_last = (rnd_reg == ROUND_LAST);
    assign digest_word     = h_reg[cmd.word_idx];

endmodule
